// File: rtl/fpdr_pkg.sv
`default_nettype none

package fpdr_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // credit working width: stored credit is 11 bits, the loop needs headroom
   localparam int CREDIT_W = 11;
   localparam int WORK_W   = 12;
   localparam int DIFF_W   = 32;
   localparam int ADV_W    = 9;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   typedef enum logic [1:0] {
      ACT_PUSH  = 2'd0,
      ACT_TICK  = 2'd1,
      ACT_PLAY  = 2'd2,
      ACT_PAUSE = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      EV_NONE        = 3'd0,
      EV_HARD_DROP   = 3'd1,
      EV_SOFT_DROP   = 3'd2,
      EV_HARD_REPEAT = 3'd3,
      EV_SOFT_REPEAT = 3'd4
   } event_type;

   localparam logic [CSR_IDX_W-1:0] REG_VIDEO_FPS     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REFRESH_RATE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HARD_LATE_MS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SOFT_EARLY_MS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_HARD_EARLY_MS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_REPEAT_LIMIT  = 3'd5;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  frame_buffer;
      logic [30:0] frame_timecode;
      logic [30:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [7:0]       shown_buffer;
      logic [30:0]      shown_timecode;
      logic [2:0]       pacing_event;
      logic [ADV_W-1:0] frames_advanced;
      logic             underrun;
      logic             push_rejected;
      logic             is_playing;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  buffer_id;
      logic [30:0] timecode;
   } slot_type;

   typedef struct packed {
      logic push;
      logic pop;
   } q_ctl_type;

   typedef struct packed {
      logic              empty;
      logic              full;
      logic [QIDX_W-1:0] head;
   } q_stat_type;

   typedef struct packed {
      logic sub;
      logic use_fps;
   } alu_ctl_type;

endpackage

`default_nettype wire

// File: rtl/fpdr_queue.sv
`default_nettype none

module fpdr_queue
   import fpdr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire q_ctl_type         ctl,
   input  wire slot_type          wr_slot,
   input  wire logic [QIDX_W-1:0] rd_addr,
   output slot_type               rd_slot,
   output q_stat_type             stat
);

   localparam int SUM_W = QIDX_W + 1;

   slot_type          mem [QUEUE_DEPTH];
   slot_type          rd_slot_ff;
   logic [QIDX_W-1:0] head_ff, head_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0]  wr_sum;
   logic [QIDX_W-1:0] wr_pos;

   // tail position, wrapped without a modulo
   always_comb begin
      wr_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
      if (wr_sum >= SUM_W'(QUEUE_DEPTH)) begin
         wr_sum = wr_sum - SUM_W'(QUEUE_DEPTH);
      end
      wr_pos = wr_sum[QIDX_W-1:0];
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (ctl.pop) begin
         head_in  = (head_ff == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end else if (ctl.push) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[wr_pos] <= wr_slot;
      end
      rd_slot_ff <= mem[rd_addr];
   end

   assign rd_slot    = rd_slot_ff;
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign stat.head  = head_ff;

endmodule

`default_nettype wire

// File: rtl/fpdr_alu.sv
`default_nettype none

module fpdr_alu
   import fpdr_pkg::*;
(
   input  wire alu_ctl_type              ctl,
   input  wire logic signed [WORK_W-1:0] acc,
   input  wire logic [7:0]               fps,
   input  wire logic [7:0]               refresh,
   output logic signed [WORK_W-1:0]      result
);

   logic signed [WORK_W-1:0] operand;

   always_comb begin
      operand = ctl.use_fps ? $signed({{(WORK_W-8){1'b0}}, fps})
                            : $signed({{(WORK_W-8){1'b0}}, refresh});
      result  = ctl.sub ? acc - operand : acc + operand;
   end

endmodule

`default_nettype wire

// File: rtl/frame_pacing_drop_repeat_top.sv
// Frame pacer for a display. Frames (buffer id, timecode) are pushed into a
// 16-entry queue; each refresh tick while playing advances through the queue
// until the signed repeat credit turns positive, then picks a hard/soft drop
// or repeat from the frame's lateness and reports the frame shown. Push, play,
// pause and a tick while paused go from the start step straight to the result
// step. A tick while playing runs the start step, the advance loop, a queue
// load step when the tick popped a frame, then the diff, decide, show and
// result steps; the advance loop does one advance per cycle through the
// single shared credit adder, which is also used for the drop/repeat adjust
// and the show step. One item is worked on at a time; a new beat is accepted
// while the previous result still waits on rsp_stall. Config writes go
// through csr_we/csr_index/csr_wdata and are meant only while the block is
// idle.
`default_nettype none

module frame_pacing_drop_repeat_top
   import fpdr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   // result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   // config write port
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_ADV,
      S_LOAD,
      S_DIFF,
      S_DECIDE,
      S_SHOW,
      S_OUT
   } state_type;

   state_type state_ff;

   // config registers
   logic [7:0]  video_fps_ff;
   logic [7:0]  refresh_rate_ff;
   logic [11:0] hard_late_ff;
   logic [10:0] soft_early_ff;
   logic [11:0] hard_early_ff;
   logic [7:0]  repeat_limit_ff;

   // pacer state
   req_type                    item_ff;
   logic [7:0]                 cur_buffer_ff;
   logic [30:0]                cur_timecode_ff;
   logic signed [CREDIT_W-1:0] credit_ff;
   logic                       fresh_ff;
   logic                       playing_ff;

   // per-item work registers
   logic signed [WORK_W-1:0] work_ff;
   logic signed [DIFF_W-1:0] diff_ff;
   logic [QIDX_W-1:0]        last_addr_ff;
   logic                     popped_ff;
   logic [2:0]               event_ff;
   logic [ADV_W-1:0]         adv_ff;
   logic                     under_ff;
   logic                     rejected_ff;

   // result register
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   // shared unit and queue hookup
   alu_ctl_type              alu_ctl;
   logic signed [WORK_W-1:0] alu_result;
   logic [7:0]               refresh_eff;
   q_ctl_type                q_ctl;
   q_stat_type               q_stat;
   slot_type                 q_wr_slot;
   slot_type                 q_rd_slot;

   // event decision inputs
   logic signed [DIFF_W-1:0] hard_late_ext;
   logic signed [DIFF_W-1:0] soft_early_ext;
   logic signed [DIFF_W-1:0] hard_early_ext;
   logic signed [WORK_W-1:0] refresh_cmp;
   logic signed [WORK_W-1:0] limit_cmp;
   logic [2:0]               event_sel;

   // a zero refresh rate counts as one so the advance loop ends
   assign refresh_eff = (refresh_rate_ff == 8'd0) ? 8'd1 : refresh_rate_ff;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // adder use by step: refresh in the loop, fps afterwards
   always_comb begin
      alu_ctl.use_fps = (state_ff != S_ADV);
      alu_ctl.sub     = 1'b1;
      if (state_ff == S_ADV) begin
         alu_ctl.sub = 1'b0;
      end else if (state_ff == S_DECIDE) begin
         alu_ctl.sub = (event_sel == EV_HARD_DROP) || (event_sel == EV_SOFT_DROP);
      end
   end

   // queue control: push in the start step, pop once per advance while frames remain
   always_comb begin
      q_ctl.push = (state_ff == S_START) && (action_type'(item_ff.action) == ACT_PUSH)
                   && !q_stat.full;
      q_ctl.pop  = (state_ff == S_ADV) && (work_ff <= 0) && !q_stat.empty;
      q_wr_slot.buffer_id = item_ff.frame_buffer;
      q_wr_slot.timecode  = item_ff.frame_timecode;
   end

   // drop/repeat choice from lateness and credit
   always_comb begin
      hard_late_ext  = {{(DIFF_W-12){hard_late_ff[11]}}, hard_late_ff};
      soft_early_ext = $signed({{(DIFF_W-11){1'b0}}, soft_early_ff});
      hard_early_ext = $signed({{(DIFF_W-12){1'b0}}, hard_early_ff});
      refresh_cmp    = $signed({{(WORK_W-8){1'b0}}, refresh_eff});
      limit_cmp      = $signed({{(WORK_W-8){1'b0}}, repeat_limit_ff});
      event_sel      = EV_NONE;
      if (diff_ff < 0) begin
         if (diff_ff < hard_late_ext) begin
            event_sel = EV_HARD_DROP;
         end else if (fresh_ff && (work_ff >= refresh_cmp)) begin
            event_sel = EV_SOFT_DROP;
         end
      end else if (diff_ff > soft_early_ext) begin
         if (diff_ff > hard_early_ext) begin
            event_sel = EV_HARD_REPEAT;
         end else if (fresh_ff && (work_ff <= limit_cmp)) begin
            event_sel = EV_SOFT_REPEAT;
         end
      end
   end

   fpdr_alu u_alu (
      .ctl     (alu_ctl),
      .acc     (work_ff),
      .fps     (video_fps_ff),
      .refresh (refresh_eff),
      .result  (alu_result)
   );

   fpdr_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .ctl     (q_ctl),
      .wr_slot (q_wr_slot),
      .rd_addr (last_addr_ff),
      .rd_slot (q_rd_slot),
      .stat    (q_stat)
   );

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         video_fps_ff    <= 8'd30;
         refresh_rate_ff <= 8'd60;
         hard_late_ff    <= -12'sd66;
         soft_early_ff   <= 11'd66;
         hard_early_ff   <= 12'd133;
         repeat_limit_ff <= 8'd60;
      end else if (csr_we) begin
         case (csr_index)
            REG_VIDEO_FPS:     video_fps_ff    <= csr_wdata[7:0];
            REG_REFRESH_RATE:  refresh_rate_ff <= csr_wdata[7:0];
            REG_HARD_LATE_MS:  hard_late_ff    <= csr_wdata[11:0];
            REG_SOFT_EARLY_MS: soft_early_ff   <= csr_wdata[10:0];
            REG_HARD_EARLY_MS: hard_early_ff   <= csr_wdata[11:0];
            REG_REPEAT_LIMIT:  repeat_limit_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         cur_buffer_ff   <= '0;
         cur_timecode_ff <= '0;
         credit_ff       <= '0;
         fresh_ff        <= 1'b0;
         playing_ff      <= 1'b0;
      end else begin
         // result beat taken
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  item_ff  <= req_data;
                  state_ff <= S_START;
               end
            end
            S_START: begin
               event_ff    <= EV_NONE;
               adv_ff      <= '0;
               under_ff    <= 1'b0;
               rejected_ff <= 1'b0;
               popped_ff   <= 1'b0;
               work_ff     <= WORK_W'(credit_ff);
               state_ff    <= S_OUT;
               case (action_type'(item_ff.action))
                  ACT_PUSH:  rejected_ff <= q_stat.full;
                  ACT_PLAY: begin
                     credit_ff  <= '0;
                     playing_ff <= 1'b1;
                  end
                  ACT_PAUSE: playing_ff <= 1'b0;
                  ACT_TICK: begin
                     if (playing_ff) begin
                        state_ff <= S_ADV;
                     end
                  end
                  default: ;
               endcase
            end
            S_ADV: begin
               // one advance per cycle while credit is not positive
               if (work_ff <= 0) begin
                  work_ff <= alu_result;
                  if (adv_ff != {ADV_W{1'b1}}) begin
                     adv_ff <= adv_ff + 1'b1;
                  end
                  if (!q_stat.empty) begin
                     last_addr_ff <= q_stat.head;
                     popped_ff    <= 1'b1;
                  end else begin
                     under_ff <= 1'b1;
                  end
               end else begin
                  // queue read of the last popped slot lands this edge
                  state_ff <= popped_ff ? S_LOAD : S_DIFF;
               end
            end
            S_LOAD: begin
               cur_buffer_ff   <= q_rd_slot.buffer_id;
               cur_timecode_ff <= q_rd_slot.timecode;
               fresh_ff        <= 1'b1;
               state_ff        <= S_DIFF;
            end
            S_DIFF: begin
               diff_ff  <= $signed({1'b0, cur_timecode_ff})
                           - $signed({1'b0, item_ff.now_ms});
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               event_ff <= event_sel;
               if (event_sel != EV_NONE) begin
                  work_ff <= alu_result;
               end
               state_ff <= S_SHOW;
            end
            S_SHOW: begin
               fresh_ff  <= 1'b0;
               credit_ff <= alu_result[CREDIT_W-1:0];
               state_ff  <= S_OUT;
            end
            S_OUT: begin
               // wait for a free result slot
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff           <= 1'b1;
                  rsp_ff.shown_buffer    <= cur_buffer_ff;
                  rsp_ff.shown_timecode  <= cur_timecode_ff;
                  rsp_ff.pacing_event    <= event_ff;
                  rsp_ff.frames_advanced <= adv_ff;
                  rsp_ff.underrun        <= under_ff;
                  rsp_ff.push_rejected   <= rejected_ff;
                  rsp_ff.is_playing      <= playing_ff;
                  state_ff               <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

// File: bench/frame_pacing_drop_repeat_top_tb.sv
`timescale 1ns / 1ps

module frame_pacing_drop_repeat_top_tb;
   import fpdr_pkg::*;

   // clock and the single reset at the start
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #1 clock = ~clock;

   // dut ports, all known from time zero
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   frame_pacing_drop_repeat_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // beats waiting for the driver, and the shows predicted for accepted beats
   req_type beats_to_send [$];
   rsp_type pacing_due [$];

   int beats_queued   = 0;
   int beats_sent     = 0;
   int beats_checked  = 0;
   int mismatch_count = 0;
   int settings_count = 0;

   // idling control
   bit   quiet     = 1'b0;
   bit   hold_go   = 1'b0;
   logic long_hold = 1'b0;
   int   gap_left  = 0;
   int   stall_left = 0;

   // coverage tallies taken from the predictor
   int ev_count [5];
   int ticks_played  = 0;
   int underruns     = 0;
   int pushes_denied = 0;

   // pacer settings as the predictor sees them, reset values
   int m_fps        = 30;
   int m_refresh    = 60;
   int m_late       = -66;
   int m_soft_early = 66;
   int m_hard_early = 133;
   int m_limit      = 60;

   // pacer state: frame queue, current frame, signed 11 bit credit
   slot_type          m_store [QUEUE_DEPTH];
   int                m_head    = 0;
   int                m_count   = 0;
   logic [7:0]        m_cur_buf = '0;
   logic [30:0]       m_cur_tc  = '0;
   logic signed [10:0] m_credit = '0;
   bit                m_fresh   = 1'b0;
   bit                m_playing = 1'b0;

   function automatic void store_setting(input logic [CSR_IDX_W-1:0] idx,
                                         input logic [CSR_DATA_W-1:0] value);
      case (idx)
         REG_VIDEO_FPS:     m_fps        = value[7:0];
         REG_REFRESH_RATE:  m_refresh    = value[7:0];
         REG_HARD_LATE_MS:  m_late       = $signed(value[11:0]);
         REG_SOFT_EARLY_MS: m_soft_early = value[10:0];
         REG_HARD_EARLY_MS: m_hard_early = value[11:0];
         REG_REPEAT_LIMIT:  m_limit      = value[7:0];
         default: ;
      endcase
   endfunction

   // works out the show for one accepted beat and updates the pacer state
   function automatic rsp_type predict_pacing(input req_type beat);
      rsp_type   res;
      event_type ev;
      int        credit;
      int        refresh;
      int        adv;
      longint    now_l;
      longint    cur_l;
      bit        under;
      bit        denied;
      ev     = EV_NONE;
      adv    = 0;
      under  = 1'b0;
      denied = 1'b0;
      case (action_type'(beat.action))
         ACT_PUSH: begin
            if (m_count >= QUEUE_DEPTH) begin
               denied = 1'b1;
               pushes_denied++;
            end else begin
               m_store[(m_head + m_count) % QUEUE_DEPTH].buffer_id = beat.frame_buffer;
               m_store[(m_head + m_count) % QUEUE_DEPTH].timecode  = beat.frame_timecode;
               m_count++;
            end
         end
         ACT_PLAY: begin
            m_credit  = '0;
            m_playing = 1'b1;
         end
         ACT_PAUSE: m_playing = 1'b0;
         default: begin
            if (m_playing) begin
               ticks_played++;
               now_l   = beat.now_ms;
               refresh = (m_refresh == 0) ? 1 : m_refresh;
               credit  = m_credit;
               // advance until the credit turns positive
               while (credit <= 0) begin
                  if (m_count > 0) begin
                     m_cur_buf = m_store[m_head].buffer_id;
                     m_cur_tc  = m_store[m_head].timecode;
                     m_head    = (m_head + 1) % QUEUE_DEPTH;
                     m_count--;
                     m_fresh   = 1'b1;
                  end else begin
                     under = 1'b1;
                  end
                  if (adv < 511) adv++;
                  credit += refresh;
               end
               // lateness of the current frame picks drop or repeat
               cur_l = m_cur_tc;
               if (cur_l < now_l) begin
                  if (cur_l < now_l + m_late) begin
                     ev = EV_HARD_DROP;
                     credit -= m_fps;
                  end else if (m_fresh && credit >= refresh) begin
                     ev = EV_SOFT_DROP;
                     credit -= m_fps;
                  end
               end else if (cur_l > now_l + m_soft_early) begin
                  if (cur_l > now_l + m_hard_early) begin
                     ev = EV_HARD_REPEAT;
                     credit += m_fps;
                  end else if (m_fresh && credit <= m_limit) begin
                     ev = EV_SOFT_REPEAT;
                     credit += m_fps;
                  end
               end
               m_fresh  = 1'b0;
               credit  -= m_fps;
               m_credit = credit[10:0];
               if (under) underruns++;
               ev_count[int'(ev)]++;
            end
         end
      endcase
      res.shown_buffer    = m_cur_buf;
      res.shown_timecode  = m_cur_tc;
      res.pacing_event    = ev;
      res.frames_advanced = ADV_W'(adv);
      res.underrun        = under;
      res.push_rejected   = denied;
      res.is_playing      = m_playing;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (mismatch_count < 100)
         $display("mismatch at result %0d: %s got 0x%0h want 0x%0h",
                  beats_checked, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_show(input rsp_type got, input rsp_type want);
      if (got.shown_buffer !== want.shown_buffer)
         report_mismatch("shown_buffer", got.shown_buffer, want.shown_buffer);
      if (got.shown_timecode !== want.shown_timecode)
         report_mismatch("shown_timecode", got.shown_timecode, want.shown_timecode);
      if (got.pacing_event !== want.pacing_event)
         report_mismatch("pacing_event", got.pacing_event, want.pacing_event);
      if (got.frames_advanced !== want.frames_advanced)
         report_mismatch("frames_advanced", got.frames_advanced, want.frames_advanced);
      if (got.underrun !== want.underrun)
         report_mismatch("underrun", got.underrun, want.underrun);
      if (got.push_rejected !== want.push_rejected)
         report_mismatch("push_rejected", got.push_rejected, want.push_rejected);
      if (got.is_playing !== want.is_playing)
         report_mismatch("is_playing", got.is_playing, want.is_playing);
   endtask

   // request driver: takes the next pending beat once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            pacing_due.push_back(predict_pacing(req_data));
            beats_sent++;
         end
         // payload may only move when nothing is held by stall
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
               gap_left = $urandom_range(0, 3);
               req_valid <= 1'b0;
            end else if (beats_to_send.size() != 0) begin
               req_data  <= beats_to_send.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor: checks every accepted beat and drives the stall bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pacing_due.size() == 0)
               report_mismatch("result beat with no show due", rsp_data, 0);
            else
               check_show(rsp_data, pacing_due.pop_front());
            beats_checked++;
         end
         if (long_hold) begin
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // long receiver hold-off so the block backs up into the request side
   initial begin
      wait (hold_go);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (400) @(posedge clock);
      long_hold <= 1'b0;
   end

   // fields arrive 32 bits wide and are cut to their widths here
   task automatic add_beat(input action_type act, input logic [31:0] fb,
                           input logic [31:0] tc, input logic [31:0] now);
      req_type beat;
      beat.action         = act;
      beat.frame_buffer   = fb[7:0];
      beat.frame_timecode = tc[30:0];
      beat.now_ms         = now[30:0];
      beats_to_send.push_back(beat);
      beats_queued++;
   endtask

   // settings only change once every show is back
   task automatic wait_drained();
      while (beats_sent != beats_queued || pacing_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      store_setting(idx, value[CSR_DATA_W-1:0]);
   endtask

   // decoder-like stream: frames pushed a little ahead of the refresh clock,
   // mixed with overfills, clock jumps, pause/play and random noise beats
   task automatic add_playback(input int n, input int frame_ms, input int tick_ms);
      longint now_l;
      longint tc_l;
      int     made;
      int     r;
      int     lead;
      int     pushes;
      now_l = $urandom_range(0, 32'h3FFF_FFFF);
      tc_l  = now_l - frame_ms;
      add_beat(ACT_PLAY, $urandom, $urandom, $urandom);
      made = 1;
      while (made < n) begin
         r = $urandom_range(0, 99);
         if (r < 78) begin
            now_l += tick_ms + int'($urandom_range(0, 4)) - 2;
            lead   = $urandom_range(0, 4 * frame_ms);
            pushes = 0;
            while (tc_l < now_l + lead && pushes < 6) begin
               tc_l += frame_ms + int'($urandom_range(0, 2)) - 1;
               add_beat(ACT_PUSH, $urandom, tc_l[30:0], $urandom);
               pushes++;
            end
            add_beat(ACT_TICK, $urandom, $urandom, now_l[30:0]);
            made += pushes + 1;
         end else if (r < 82) begin
            // overfill so the queue turns pushes away
            pushes = $urandom_range(17, 20);
            repeat (pushes) begin
               tc_l += frame_ms;
               add_beat(ACT_PUSH, $urandom, tc_l[30:0], $urandom);
            end
            made += pushes;
         end else if (r < 87) begin
            // presentation clock jumps either way
            now_l += int'($urandom_range(0, 6000)) - 3000;
            if (now_l < 0) now_l = 0;
            add_beat(ACT_TICK, $urandom, $urandom, now_l[30:0]);
            made++;
         end else if (r < 93) begin
            add_beat(ACT_PAUSE, $urandom, $urandom, $urandom);
            add_beat(ACT_TICK, $urandom, $urandom, now_l[30:0]);
            add_beat(ACT_PLAY, $urandom, $urandom, $urandom);
            made += 3;
         end else begin
            add_beat(action_type'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
            made++;
         end
      end
   endtask

   task automatic run_phase(input int fps, input int refresh, input int late_ms,
                            input int soft_early, input int hard_early, input int limit,
                            input int n);
      int f;
      int r;
      wait_drained();
      write_reg(REG_VIDEO_FPS, fps);
      write_reg(REG_REFRESH_RATE, refresh);
      write_reg(REG_HARD_LATE_MS, late_ms);
      write_reg(REG_SOFT_EARLY_MS, soft_early);
      write_reg(REG_HARD_EARLY_MS, hard_early);
      write_reg(REG_REPEAT_LIMIT, limit);
      @(posedge clock);
      csr_we <= 1'b0;
      settings_count++;
      // stream periods follow the rates just programmed
      f = fps & 255;
      if (f == 0) f = 1;
      r = refresh & 255;
      if (r == 0) r = 1;
      add_playback(n, (1000 + f / 2) / f, 1000 / r);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      settings_count = 1;

      // directed beats on the reset settings (30 fps video, 60 Hz display)
      add_beat(ACT_TICK, 8'hFF, 31'h7FFF_FFFF, 0);     // tick while paused
      add_beat(ACT_PAUSE, 0, 0, 31'h7FFF_FFFF);
      add_beat(ACT_PLAY, 8'hFF, 31'h7FFF_FFFF, 0);
      add_beat(ACT_TICK, 0, 0, 5);                      // empty queue, underrun
      add_beat(ACT_PUSH, 8'h00, 31'h0, 31'h7FFF_FFFF);
      add_beat(ACT_PUSH, 8'hFF, 31'h7FFF_FFFF, 0);
      add_beat(ACT_PUSH, 8'h5A, 1000, 0);
      add_beat(ACT_PUSH, 8'hA5, 2000, 0);
      add_beat(ACT_PUSH, 8'h3C, 3000, 0);
      add_beat(ACT_PLAY, 0, 0, 0);
      add_beat(ACT_TICK, 0, 0, 100);                    // hard drop
      add_beat(ACT_TICK, 0, 0, 200);                    // hard repeat, top timecode
      add_beat(ACT_TICK, 0, 0, 31'h7FFF_FFFF);          // on time, no advance
      add_beat(ACT_PLAY, 0, 0, 0);
      add_beat(ACT_TICK, 0, 0, 1030);                   // soft drop
      add_beat(ACT_TICK, 0, 0, 1900);                   // soft repeat
      add_beat(ACT_TICK, 0, 0, 2980);                   // stale frame, hard drop
      add_beat(ACT_TICK, 0, 0, 3000);
      add_beat(ACT_TICK, 0, 0, 3010);
      add_beat(ACT_TICK, 0, 0, 3020);                   // queue ran dry
      add_beat(ACT_PAUSE, 0, 0, 0);
      add_beat(ACT_TICK, 0, 0, 4000);
      add_beat(ACT_PUSH, 8'h81, 31'h4000_0001, 31'h7FFF_FFFF);

      run_phase(24, 60, -83, 83, 166, 48, 140);
      hold_go = 1'b1;
      run_phase(1, 1, -2000, 2000, 4000, 0, 140);
      run_phase(240, 240, 0, 0, 0, 240, 140);
      // zero refresh with a fast video rate: long advance runs
      run_phase(255, 0, 2047, 0, 0, 0, 140);
      run_phase(0, 1, -1, 1, 1, 1, 60);
      run_phase(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 140);
      run_phase($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095),
                $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095),
                140);
      quiet = 1'b1;
      run_phase(60, 144, -33, 33, 66, 144, 140);

      wait_drained();
      repeat (20) @(posedge clock);
      $display("covered %0d beats under %0d register settings: %0d played ticks,",
               beats_checked, settings_count, ticks_played);
      $display("  %0d underruns, %0d refused pushes", underruns, pushes_denied);
      $display("pacing: %0d hard drops, %0d soft drops, %0d hard repeats,",
               ev_count[EV_HARD_DROP], ev_count[EV_SOFT_DROP], ev_count[EV_HARD_REPEAT]);
      $display("  %0d soft repeats, %0d plain", ev_count[EV_SOFT_REPEAT], ev_count[EV_NONE]);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // watchdog far beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: filelist.f
rtl/fpdr_pkg.sv
rtl/fpdr_queue.sv
rtl/fpdr_alu.sv
rtl/frame_pacing_drop_repeat_top.sv
bench/frame_pacing_drop_repeat_top_tb.sv
